FILE: src/pfde_pkg.sv
// Shared constants of the planar framebuffer draw engine.
package pfde_pkg;

  localparam logic [1:0] MODE_FILL    = 2'd0;
  localparam logic [1:0] MODE_OUTLINE = 2'd1;
  localparam logic [1:0] MODE_GLYPH   = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PLANES = 2'd2;

  localparam logic [7:0] MASK_FULL  = 8'hff;
  localparam logic [3:0] GLYPH_ROWS = 4'd8;

  localparam logic [1:0] PASS_FILL_LAST    = 2'd0;
  localparam logic [1:0] PASS_OUTLINE_LAST = 2'd3;

endpackage

FILE: src/planar_framebuffer_draw_engine_core.sv
// Top level: bit-planar frame store with rectangle, outline, glyph and byte-read commands.
//
// Command channel (cmd_valid / cmd_stall) takes one command word: mode, position,
// size, thickness, color, glyph rows and read plane. Response channel
// (rsp_valid / rsp_stall) returns one word per command: the store byte for a
// read, zero for every drawing command.
// Config port: cfg_we with cfg_index / cfg_data; width, height and plane count
// are clamped on write. Write only while no command is in flight.
// Walk: a drawing command walks every covered byte in every active plane with
// a read-modify-write on the single store port, row by row and pass by pass (4
// passes for an outline), so time grows with the clipped area times plane_count.
// A read passes the setup states and S_RD0 to S_RD3 before its word is ready; an
// off-screen command goes from setup straight to done. The next command is taken
// the cycle after its predecessor's word is loaded; cmd_stall is high until then.
// Reset: the layout registers and rsp_valid return to their defaults and a
// clearing pass writes zero to every store byte, one byte per cycle; commands
// stall meanwhile.
// Response stall: the finished word sits in the output register; the next command
// is accepted meanwhile and waits only when its own word is ready.
module planar_framebuffer_draw_engine_core #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480,
  parameter int MAX_PLANES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  mode,
  input  logic [9:0]  pos_x,
  input  logic [9:0]  pos_y,
  input  logic [9:0]  size_x,
  input  logic [9:0]  size_y,
  input  logic [7:0]  thickness,
  input  logic [3:0]  color,
  input  logic [63:0] glyph_bits,
  input  logic [3:0]  glyph_rows,
  input  logic [1:0]  read_plane,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  read_data
);

  localparam int STORE_BYTES = (MAX_WIDTH / 8) * MAX_HEIGHT * MAX_PLANES;
  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [10:0] MAXW  = 11'(MAX_WIDTH - (MAX_WIDTH % 8));
  localparam logic [10:0] MAXH  = 11'(MAX_HEIGHT);
  localparam logic [3:0]  MAXP  = 4'(MAX_PLANES);
  localparam logic [9:0]  RST_W = (MAXW < 11'd640) ? MAXW[9:0] : 10'd640;
  localparam logic [8:0]  RST_H = (MAXH < 11'd480) ? MAXH[8:0] : 9'd480;
  localparam logic [2:0]  RST_P = (MAXP < 4'd4) ? MAXP[2:0] : 3'd4;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_SETUP2 = 4'd3;
  localparam logic [3:0] S_PASS   = 4'd4;
  localparam logic [3:0] S_ROW    = 4'd5;
  localparam logic [3:0] S_RMW0   = 4'd6;
  localparam logic [3:0] S_RMW1   = 4'd7;
  localparam logic [3:0] S_NEXT   = 4'd8;
  localparam logic [3:0] S_RD0    = 4'd9;
  localparam logic [3:0] S_RD1    = 4'd10;
  localparam logic [3:0] S_RD2    = 4'd11;
  localparam logic [3:0] S_RD3    = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  // layout registers
  logic [9:0] screen_width;
  logic [8:0] screen_height;
  logic [2:0] plane_count;

  logic [3:0] state;
  logic [AW-1:0] clr_cnt;

  // latched command word
  logic [1:0]  c_mode;
  logic [9:0]  c_px, c_py, c_sx, c_sy;
  logic [7:0]  c_thick;
  logic [3:0]  c_color;
  logic [63:0] c_gbits;
  logic [3:0]  c_grows;
  logic [1:0]  c_rplane;

  // clipped geometry
  logic [9:0] w_r, h_r, tv_r, th_r;
  logic [AW-1:0] plane_bytes;

  // pass / row walker
  logic [1:0] pass_idx;
  logic [9:0] y_cur, rows_left, span_x, span_len;
  logic [2:0] g_row;
  logic [6:0] first_b, last_b, byte_idx;
  logic [7:0] lmask, rmask;
  logic [2:0] plane_idx;
  logic [AW-1:0] pbase, rowb, waddr;
  logic [7:0] result;

  // store port
  logic [7:0] frame_store [STORE_BYTES];
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= frame_store[mem_raddr];
    end
  end

  logic [6:0] row_bytes;
  assign row_bytes = screen_width[9:3];

  // merge of the current byte
  logic [7:0] cur_mask;
  logic [7:0] color_ext;
  logic       set_bit;
  assign color_ext = {4'b0, c_color};
  assign set_bit   = color_ext[plane_idx];
  assign cur_mask  = (byte_idx == first_b) ? lmask :
                     (byte_idx == last_b) ? rmask : pfde_pkg::MASK_FULL;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = waddr;
    mem_wdata = set_bit ? (mem_rdata | cur_mask) : (mem_rdata & ~cur_mask);
    mem_raddr = pbase + rowb + AW'(byte_idx);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = 8'd0;
      end
      S_RMW0: mem_re = 1'b1;
      S_RMW1: mem_we = 1'b1;
      S_RD2: begin
        mem_re    = 1'b1;
        mem_raddr = pbase + rowb + AW'(c_px[9:3]);
      end
      default: ;
    endcase
  end

  assign cmd_stall = (state != S_IDLE);

  // finished word moves into the output register
  logic rsp_load;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // clipped sizes and pass parameters
  logic [9:0] avail_w, avail_h, w_clip, h_clip;
  assign avail_w = screen_width - c_px;
  assign avail_h = {1'b0, screen_height} - c_py;
  assign w_clip  = (c_sx > avail_w) ? avail_w : c_sx;
  assign h_clip  = (c_sy > avail_h) ? avail_h : c_sy;

  logic [10:0] two_tv;
  logic [9:0]  mid_rows;
  logic [3:0]  g_lim;
  logic [9:0]  g_rows_clip;
  assign two_tv      = {tv_r, 1'b0};
  assign mid_rows    = ({1'b0, h_r} > two_tv) ? 10'({1'b0, h_r} - two_tv) : 10'd0;
  assign g_lim       = (c_grows > pfde_pkg::GLYPH_ROWS) ? pfde_pkg::GLYPH_ROWS : c_grows;
  assign g_rows_clip = ({6'd0, g_lim} > avail_h) ? avail_h : {6'd0, g_lim};

  logic [9:0] p_y, p_rows, p_x, p_len;
  always_comb begin
    p_y    = c_py;
    p_rows = h_r;
    p_x    = c_px;
    p_len  = w_r;
    case (c_mode)
      pfde_pkg::MODE_OUTLINE: begin
        case (pass_idx)
          2'd0: p_rows = tv_r;
          2'd1: begin
            p_y    = c_py + h_r - tv_r;
            p_rows = tv_r;
          end
          2'd2: begin
            p_y    = c_py + tv_r;
            p_rows = mid_rows;
            p_len  = th_r;
          end
          default: begin
            p_y    = c_py + tv_r;
            p_rows = mid_rows;
            p_x    = c_px + w_r - th_r;
            p_len  = th_r;
          end
        endcase
      end
      pfde_pkg::MODE_GLYPH: p_rows = g_rows_clip;
      default: ;
    endcase
  end

  // row masks: spans for rectangles, shifted glyph row for glyphs
  logic [9:0]  last_px;
  logic [6:0]  s_first, s_last;
  logic [7:0]  s_lmask, s_rmask;
  logic [7:0]  g_bits_row;
  logic [15:0] g_shift;
  logic        g_two;
  always_comb begin
    last_px    = span_x + span_len - 10'd1;
    g_bits_row = c_gbits[{g_row, 3'b000} +: 8];
    g_shift    = {g_bits_row, 8'd0} >> c_px[2:0];
    g_two      = (c_px[2:0] != 3'd0) && (({1'b0, c_px[9:3]} + 8'd1) < {1'b0, row_bytes});
    if (c_mode == pfde_pkg::MODE_GLYPH) begin
      s_first = c_px[9:3];
      s_last  = g_two ? 7'(c_px[9:3] + 7'd1) : c_px[9:3];
      s_lmask = g_shift[15:8];
      s_rmask = g_shift[7:0];
    end else begin
      s_first = span_x[9:3];
      s_last  = last_px[9:3];
      s_lmask = pfde_pkg::MASK_FULL >> span_x[2:0];
      s_rmask = pfde_pkg::MASK_FULL << (3'd7 - last_px[2:0]);
      if (s_first == s_last) begin
        s_lmask = s_lmask & s_rmask;
      end
    end
  end

  logic [1:0] last_pass;
  assign last_pass = (c_mode == pfde_pkg::MODE_OUTLINE) ? pfde_pkg::PASS_OUTLINE_LAST
                                                        : pfde_pkg::PASS_FILL_LAST;

  // clamped config values
  logic [10:0] cw, ch;
  logic [3:0]  cp;
  always_comb begin
    cw = {1'b0, cfg_data};
    if (cw > MAXW) cw = MAXW;
    cw[2:0] = 3'b000;
    if (cw < 11'd8) cw = 11'd8;
    ch = {2'b0, cfg_data[8:0]};
    if (ch > MAXH) ch = MAXH;
    if (ch < 11'd1) ch = 11'd1;
    cp = {1'b0, cfg_data[2:0]};
    if (cp > MAXP) cp = MAXP;
    if (cp < 4'd1) cp = 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      rsp_valid     <= 1'b0;
      screen_width  <= RST_W;
      screen_height <= RST_H;
      plane_count   <= RST_P;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pfde_pkg::REG_WIDTH:  screen_width  <= cw[9:0];
          pfde_pkg::REG_HEIGHT: screen_height <= ch[8:0];
          pfde_pkg::REG_PLANES: plane_count   <= cp[2:0];
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(STORE_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c_mode   <= mode;
            c_px     <= pos_x;
            c_py     <= pos_y;
            c_sx     <= size_x;
            c_sy     <= size_y;
            c_thick  <= thickness;
            c_color  <= color;
            c_gbits  <= glyph_bits;
            c_grows  <= glyph_rows;
            c_rplane <= read_plane;
            state    <= S_SETUP;
          end
        end
        S_SETUP: begin
          result <= 8'd0;
          if (c_px >= screen_width || c_py >= {1'b0, screen_height}) begin
            state <= S_DONE;
          end else begin
            w_r   <= w_clip;
            h_r   <= h_clip;
            state <= S_SETUP2;
          end
        end
        S_SETUP2: begin
          tv_r        <= ({2'b0, c_thick} > h_r) ? h_r : {2'b0, c_thick};
          th_r        <= ({2'b0, c_thick} > w_r) ? w_r : {2'b0, c_thick};
          plane_bytes <= AW'(row_bytes * screen_height);
          pass_idx    <= 2'd0;
          if (c_mode == pfde_pkg::MODE_READ) begin
            state <= S_RD0;
          end else if (c_mode == pfde_pkg::MODE_GLYPH) begin
            state <= S_PASS;
          end else if (w_r == 10'd0 || h_r == 10'd0 ||
                       (c_mode == pfde_pkg::MODE_OUTLINE && c_thick == 8'd0)) begin
            state <= S_DONE;
          end else begin
            state <= S_PASS;
          end
        end
        S_PASS: begin
          y_cur     <= p_y;
          rows_left <= p_rows;
          span_x    <= p_x;
          span_len  <= p_len;
          g_row     <= 3'd0;
          state     <= (p_rows == 10'd0) ? S_NEXT : S_ROW;
        end
        S_ROW: begin
          first_b   <= s_first;
          last_b    <= s_last;
          lmask     <= s_lmask;
          rmask     <= s_rmask;
          byte_idx  <= s_first;
          plane_idx <= 3'd0;
          pbase     <= '0;
          rowb      <= AW'(y_cur * row_bytes);
          state     <= S_RMW0;
        end
        S_RMW0: begin
          waddr <= mem_raddr;
          state <= S_RMW1;
        end
        S_RMW1: begin
          if (byte_idx != last_b) begin
            byte_idx <= byte_idx + 7'd1;
            state    <= S_RMW0;
          end else if (({1'b0, plane_idx} + 4'd1) < {1'b0, plane_count}) begin
            plane_idx <= plane_idx + 3'd1;
            pbase     <= pbase + plane_bytes;
            byte_idx  <= first_b;
            state     <= S_RMW0;
          end else if (rows_left == 10'd1) begin
            state <= S_NEXT;
          end else begin
            rows_left <= rows_left - 10'd1;
            y_cur     <= y_cur + 10'd1;
            g_row     <= g_row + 3'd1;
            state     <= S_ROW;
          end
        end
        S_NEXT: begin
          if (pass_idx == last_pass) begin
            state <= S_DONE;
          end else begin
            pass_idx <= pass_idx + 2'd1;
            state    <= S_PASS;
          end
        end
        S_RD0: begin
          pbase <= AW'(c_rplane * plane_bytes);
          state <= ({1'b0, c_rplane} < plane_count) ? S_RD1 : S_DONE;
        end
        S_RD1: begin
          rowb  <= AW'(c_py * row_bytes);
          state <= S_RD2;
        end
        S_RD2: state <= S_RD3;
        S_RD3: begin
          result <= mem_rdata;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            read_data <= result;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a drawing read of the store is always followed by its merge write
  a_rmw_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW0) |=> (state == S_RMW1))
    else $error("read-modify-write not paired");

  // the byte walker never runs past the row's last byte
  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW1) |-> (byte_idx <= last_b) && (byte_idx >= first_b))
    else $error("byte index outside span");

  // plane walker stays inside the configured planes
  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW1) |-> ({1'b0, plane_idx} < {1'b0, plane_count}))
    else $error("plane index outside plane count");

  // no command is taken during the clearing pass
  a_clear_stall: assert property (@(posedge clk)
    (state == S_CLEAR) |-> cmd_stall)
    else $error("command accepted while clearing");

endmodule

FILE: tb/planar_framebuffer_draw_engine_core_test.sv
// Self-checking testbench for the planar framebuffer draw engine core.
module planar_framebuffer_draw_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 640;
  localparam int MAX_H = 480;
  localparam int MAX_P = 4;
  localparam int STORE_SIZE = (MAX_W / 8) * MAX_H * MAX_P;

  typedef struct {
    logic [1:0]  mode;
    logic [9:0]  px;
    logic [9:0]  py;
    logic [9:0]  sx;
    logic [9:0]  sy;
    logic [7:0]  thick;
    logic [3:0]  col;
    logic [63:0] gbits;
    logic [3:0]  grows;
    logic [1:0]  rplane;
  } draw_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = pfde_pkg::REG_WIDTH;
  logic [9:0]  cfg_data = '0;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [1:0]  mode = pfde_pkg::MODE_FILL;
  logic [9:0]  pos_x = '0;
  logic [9:0]  pos_y = '0;
  logic [9:0]  size_x = '0;
  logic [9:0]  size_y = '0;
  logic [7:0]  thickness = '0;
  logic [3:0]  color = '0;
  logic [63:0] glyph_bits = '0;
  logic [3:0]  glyph_rows = '0;
  logic [1:0]  read_plane = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [7:0]  read_data;

  // shadow of the frame store and the layout registers
  logic [7:0]  shadow_store [STORE_SIZE];
  int unsigned scr_w;
  int unsigned scr_h;
  int unsigned planes;

  logic [7:0]  pending_bytes[$];
  int          errors = 0;
  int          hold_left = 0;  // receiver hold-off, counted down per cycle
  bit          calm = 1'b0;    // no idling on either side while set

  planar_framebuffer_draw_engine_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #300_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report(input string msg);
    errors++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // ---------------- predictor ----------------
  function automatic void merge(int unsigned idx, logic [7:0] m, bit set);
    if (idx >= STORE_SIZE) return;
    shadow_store[idx] = set ? (shadow_store[idx] | m) : (shadow_store[idx] & ~m);
  endfunction

  function automatic void span(int unsigned x, int unsigned y, int unsigned len,
                               logic [3:0] col);
    int unsigned first, lpx, last, base, rb;
    logic [7:0] lm, rm;
    if (len == 0) return;
    rb = scr_w >> 3;
    first = x >> 3;
    lpx = x + len - 1;
    last = lpx >> 3;
    lm = 8'hff >> (x & 7);
    rm = 8'hff << (7 - (lpx & 7));
    for (int unsigned p = 0; p < planes; p++) begin
      base = p * rb * scr_h + y * rb;
      if (first == last) begin
        merge(base + first, lm & rm, col[p]);
      end else begin
        merge(base + first, lm, col[p]);
        for (int unsigned b = first + 1; b < last; b++)
          merge(base + b, pfde_pkg::MASK_FULL, col[p]);
        merge(base + last, rm, col[p]);
      end
    end
  endfunction

  function automatic void block(int unsigned x, int unsigned y, int unsigned w,
                                int unsigned h, logic [3:0] col);
    for (int unsigned r = 0; r < h; r++) span(x, y + r, w, col);
  endfunction

  function automatic logic [7:0] predict_byte(draw_cmd_t c);
    int unsigned w, h, tv, th, gr, idx;
    logic [7:0] bits;
    if (c.px >= scr_w || c.py >= scr_h) return 8'h00;
    w = (c.sx > scr_w - c.px) ? scr_w - c.px : c.sx;
    h = (c.sy > scr_h - c.py) ? scr_h - c.py : c.sy;
    case (c.mode)
      pfde_pkg::MODE_FILL: if (w != 0 && h != 0) block(c.px, c.py, w, h, c.col);
      pfde_pkg::MODE_OUTLINE: begin
        if (w != 0 && h != 0 && c.thick != 0) begin
          tv = (c.thick > h) ? h : c.thick;
          th = (c.thick > w) ? w : c.thick;
          block(c.px, c.py, w, tv, c.col);
          block(c.px, c.py + h - tv, w, tv, c.col);
          for (int unsigned r = c.py + tv; r + tv < c.py + h; r++) begin
            span(c.px, r, th, c.col);
            span(c.px + w - th, r, th, c.col);
          end
        end
      end
      pfde_pkg::MODE_GLYPH: begin
        gr = (c.grows > pfde_pkg::GLYPH_ROWS) ? pfde_pkg::GLYPH_ROWS : c.grows;
        for (int unsigned r = 0; r < gr; r++) begin
          bits = c.gbits[8*r +: 8];
          if (c.py + r >= scr_h) break;
          for (int unsigned k = 0; k < 8; k++)
            if (bits[7-k] && c.px + k < scr_w) span(c.px + k, c.py + r, 1, c.col);
        end
      end
      default: begin
        if (c.rplane < planes) begin
          idx = c.rplane * (scr_w >> 3) * scr_h + c.py * (scr_w >> 3) + (c.px >> 3);
          if (idx < STORE_SIZE) return shadow_store[idx];
        end
      end
    endcase
    return 8'h00;
  endfunction

  // ---------------- response side ----------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 33);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected word read_data=%02h", read_data));
      end else begin
        if (read_data !== pending_bytes[0])
          report($sformatf("read_data %02h, want %02h", read_data, pending_bytes[0]));
        void'(pending_bytes.pop_front());
      end
    end
  end

  // ---------------- command side ----------------
  // Leaves cmd_valid high after acceptance; the next call or park_cmd settles it.
  task automatic send_cmd(input draw_cmd_t c);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 33) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    mode <= c.mode;
    pos_x <= c.px;
    pos_y <= c.py;
    size_x <= c.sx;
    size_y <= c.sy;
    thickness <= c.thick;
    color <= c.col;
    glyph_bits <= c.gbits;
    glyph_rows <= c.grows;
    read_plane <= c.rplane;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    pending_bytes.push_back(predict_byte(c));
  endtask

  task automatic park_cmd();
    @(negedge clk);
    cmd_valid <= 1'b0;
  endtask

  task automatic drain();
    park_cmd();
    wait (pending_bytes.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    int unsigned v;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[9:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pfde_pkg::REG_WIDTH: begin
        v = val & 10'h3ff;
        if (v > MAX_W) v = MAX_W;
        v = v & ~32'd7;
        scr_w = (v < 8) ? 8 : v;
      end
      pfde_pkg::REG_HEIGHT: begin
        v = val & 9'h1ff;
        if (v > MAX_H) v = MAX_H;
        scr_h = (v < 1) ? 1 : v;
      end
      default: begin
        v = val & 3'h7;
        if (v > MAX_P) v = MAX_P;
        planes = (v < 1) ? 1 : v;
      end
    endcase
  endtask

  task automatic set_layout(input int unsigned w, input int unsigned h, input int unsigned p);
    write_reg(pfde_pkg::REG_WIDTH, w);
    write_reg(pfde_pkg::REG_HEIGHT, h);
    write_reg(pfde_pkg::REG_PLANES, p);
  endtask

  function automatic draw_cmd_t mk(logic [1:0] md, int unsigned x, int unsigned y,
                                   int unsigned sx, int unsigned sy, int unsigned th,
                                   int unsigned col, logic [63:0] gb, int unsigned gr,
                                   int unsigned rp);
    draw_cmd_t c;
    c.mode = md; c.px = 10'(x); c.py = 10'(y); c.sx = 10'(sx); c.sy = 10'(sy);
    c.thick = 8'(th); c.col = 4'(col); c.gbits = gb; c.grows = 4'(gr);
    c.rplane = 2'(rp);
    return c;
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int unsigned lim;
    lim = (scr_w * scr_h > 4096) ? 32 : 80;
    c.mode = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 8) begin
      c.px = 10'($urandom_range(0, 1023));
      c.py = 10'($urandom_range(0, 1023));
    end else begin
      c.px = 10'($urandom_range(0, scr_w + 4 > 1023 ? 1023 : scr_w + 4));
      c.py = 10'($urandom_range(0, scr_h + 2 > 1023 ? 1023 : scr_h + 2));
    end
    c.sx = 10'(($urandom_range(0, 19) == 0 && lim == 80) ? 1023 : $urandom_range(0, lim));
    c.sy = 10'(($urandom_range(0, 19) == 0 && lim == 80) ? 1023 : $urandom_range(0, lim));
    c.thick = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
    c.col = 4'($urandom_range(0, 15));
    c.gbits = {$urandom, $urandom};
    c.grows = 4'($urandom_range(0, 15));
    c.rplane = 2'($urandom_range(0, 3));
    return c;
  endfunction

  // ---------------- tests ----------------
  task automatic test_default_layout();
    // full screen fill at the largest layout, then corners
    send_cmd(mk(pfde_pkg::MODE_FILL, 0, 0, 1023, 1023, 0, 4'ha, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, '0, 0, 1));
    send_cmd(mk(pfde_pkg::MODE_READ, 639, 479, 0, 0, 0, 0, '0, 0, 3));
    send_cmd(mk(pfde_pkg::MODE_READ, 639, 479, 0, 0, 0, 0, '0, 0, 0));
    // partial masks, thin and thick outlines, empty cases
    send_cmd(mk(pfde_pkg::MODE_FILL, 3, 2, 11, 3, 0, 4'h5, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_OUTLINE, 20, 10, 30, 20, 3, 4'h0, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_OUTLINE, 100, 100, 5, 4, 255, 4'hf, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_OUTLINE, 600, 470, 1023, 1023, 2, 4'h3, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_OUTLINE, 50, 50, 10, 10, 0, 4'h0, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_FILL, 60, 60, 0, 10, 0, 4'h0, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_FILL, 640, 0, 5, 5, 0, 4'h0, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_FILL, 0, 1023, 5, 5, 0, 4'h0, '0, 0, 0));
    // glyphs: no rows, clamped rows, right and bottom edges
    send_cmd(mk(pfde_pkg::MODE_GLYPH, 200, 200, 0, 0, 0, 4'h0,
                64'hffff_ffff_ffff_ffff, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_GLYPH, 201, 200, 0, 0, 0, 4'h9,
                64'h8142_2418_1824_4281, 15, 0));
    send_cmd(mk(pfde_pkg::MODE_GLYPH, 636, 476, 0, 0, 0, 4'h6,
                64'hffff_ffff_ffff_ffff, 9, 0));
    send_cmd(mk(pfde_pkg::MODE_READ, 632, 479, 0, 0, 0, 0, '0, 0, 1));
    send_cmd(mk(pfde_pkg::MODE_READ, 200, 203, 0, 0, 0, 0, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_READ, 8, 2, 0, 0, 0, 0, '0, 0, 2));
    send_cmd(mk(pfde_pkg::MODE_READ, 1023, 1023, 0, 0, 0, 0, '0, 0, 3));
  endtask

  task automatic test_layout_extremes();
    // smallest layout, out-of-range writes clamp, unused plane reads zero
    set_layout(0, 0, 0);
    send_cmd(mk(pfde_pkg::MODE_FILL, 0, 0, 1023, 1023, 0, 4'hf, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, '0, 0, 1));
    set_layout(1023, 511, 7);
    send_cmd(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, '0, 0, 0));
    send_cmd(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, '0, 0, 3));
    set_layout(13, 3, 2);
    send_cmd(mk(pfde_pkg::MODE_GLYPH, 2, 0, 0, 0, 0, 4'h3, {$urandom, $urandom}, 8, 0));
    send_cmd(mk(pfde_pkg::MODE_READ, 0, 1, 0, 0, 0, 0, '0, 0, 1));
    send_cmd(mk(pfde_pkg::MODE_READ, 0, 1, 0, 0, 0, 0, '0, 0, 2));
  endtask

  task automatic test_backpressure();
    // receiver holds off while commands keep coming, so the input stalls
    set_layout(32, 8, 4);
    @(negedge clk);
    hold_left <= 300;
    for (int i = 0; i < 6; i++) send_cmd(random_cmd());
    // sender pauses until every word is back
    drain();
    for (int i = 0; i < 6; i++) send_cmd(random_cmd());
  endtask

  task automatic test_random_phases();
    int unsigned w, h, p;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 5))
        0: begin w = 8; h = 1; end
        1: begin w = 640; h = 480; end
        2: begin w = $urandom_range(0, 1023); h = $urandom_range(1, 8); end
        default: begin w = $urandom_range(1, 8) * 8; h = $urandom_range(1, 24); end
      endcase
      if (ph == 0) begin w = 8; h = 1; end
      p = (ph == 1) ? 1 : $urandom_range(0, 7);
      set_layout(w, h, p);
      calm = (ph == 5);
      for (int i = 0; i < 70; i++) send_cmd(random_cmd());
      calm = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < STORE_SIZE; i++) shadow_store[i] = 8'h00;
    scr_w = MAX_W;
    scr_h = MAX_H;
    planes = MAX_P;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_layout();
    test_layout_extremes();
    test_backpressure();
    test_random_phases();

    park_cmd();
    wait (pending_bytes.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
